// File: rtl/core/note_string_parser_macros.svh
// Assertion macros shared by the note string parser RTL.
// Expects clk and rst_n in the scope of every use; no other dependencies.
`ifndef NOTE_STRING_PARSER_MACROS_SVH
`define NOTE_STRING_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define NSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("note_string_parser: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define NSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("note_string_parser: next-cycle check failed");

`endif

// File: rtl/core/nsp_pkg.sv
// Types, command codes, character constants and defaults for the note string parser.
// No dependencies; used by the interfaces, the word queue and the top level.
package nsp_pkg;

    typedef logic [7:0]        sym_t;
    typedef logic [3:0]        code_t;
    typedef logic signed [5:0] shift_t;
    typedef logic [2:0]        octave_t;
    typedef logic [6:0]        level_t;
    typedef logic [10:0]       dur_t;
    typedef logic [1:0]        phase_t;

    // One note word as it leaves the block
    typedef struct packed {
        code_t   code;
        shift_t  semitones;
        octave_t octave;
        level_t  level;
        dur_t    duration;
        logic    run_end;
    } note_word_t;

    // Up to two words written into the output queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        note_word_t w0;
        note_word_t w1;
    } push_t;

    // Command codes
    localparam code_t CODE_NOTE_A     = 4'd0;
    localparam code_t CODE_NOTE_G     = 4'd6;
    localparam code_t CODE_REST       = 4'd7;
    localparam code_t CODE_PLUS       = 4'd8;
    localparam code_t CODE_MINUS      = 4'd9;
    localparam code_t CODE_SHARP      = 4'd10;
    localparam code_t CODE_NATURAL    = 4'd11;
    localparam code_t CODE_OCT_UP     = 4'd12;
    localparam code_t CODE_OCT_DOWN   = 4'd13;
    localparam code_t CODE_VELOCITY   = 4'd14;
    localparam code_t CODE_MODULATION = 4'd15;

    // Characters
    localparam sym_t CHAR_A      = 8'h41;
    localparam sym_t CHAR_G      = 8'h47;
    localparam sym_t CHAR_R      = 8'h52;
    localparam sym_t CHAR_0      = 8'h30;
    localparam sym_t CHAR_9      = 8'h39;
    localparam sym_t CHAR_PLUS   = 8'h2B;
    localparam sym_t CHAR_MINUS  = 8'h2D;
    localparam sym_t CHAR_HASH   = 8'h23;
    localparam sym_t CHAR_EQUAL  = 8'h3D;
    localparam sym_t CHAR_LBRACK = 8'h5B;
    localparam sym_t CHAR_LESS   = 8'h3C;
    localparam sym_t CHAR_RBRACK = 8'h5D;
    localparam sym_t CHAR_MORE   = 8'h3E;
    localparam sym_t CHAR_V      = 8'h76;
    localparam sym_t CHAR_M      = 8'h6D;

    // Defaults and limits
    localparam dur_t    DEF_LENGTH   = 11'd120;
    localparam dur_t    MAX_LENGTH   = 11'd2047;
    localparam level_t  DEF_LEVEL    = 7'd100;
    localparam level_t  MAX_LEVEL    = 7'd127;
    localparam shift_t  SHIFT_MAX    = 6'sd31;
    localparam shift_t  SHIFT_MIN    = -6'sd32;
    localparam octave_t OCT_MAX      = 3'd7;
    localparam shift_t  RST_START_SHIFT  = 6'sd1;
    localparam octave_t RST_START_OCTAVE = 3'd4;

    // Register index (paddr bit 2)
    localparam logic REG_START_SHIFT  = 1'b0;
    localparam logic REG_START_OCTAVE = 1'b1;

    // Output queue depth (at least two)
    localparam int NSP_FIFO_DEPTH = 4;

endpackage

// File: rtl/core/nsp_in_if.sv
// Character channel into the note string parser: valid/ready plus one character.
// Depends on nsp_pkg.
interface nsp_in_if;
    logic          valid;
    logic          ready;
    nsp_pkg::sym_t symbol;
    logic          string_end;

    modport source (output valid, output symbol, output string_end, input ready);
    modport sink   (input valid, input symbol, input string_end, output ready);
endinterface

// File: rtl/core/nsp_out_if.sv
// Note word channel out of the note string parser: valid/ready plus one word.
// Depends on nsp_pkg.
interface nsp_out_if;
    logic             valid;
    logic             ready;
    nsp_pkg::code_t   code;
    nsp_pkg::shift_t  semitones;
    nsp_pkg::octave_t octave;
    nsp_pkg::level_t  level;
    nsp_pkg::dur_t    duration;
    logic             run_end;

    modport source (output valid, output code, output semitones, output octave,
                    output level, output duration, output run_end, input ready);
    modport sink   (input valid, input code, input semitones, input octave,
                    input level, input duration, input run_end, output ready);
endinterface

// File: rtl/core/nsp_out_fifo.sv
// Output word queue: takes up to two words per cycle, hands out one per beat.
// Depends on nsp_pkg and nsp_out_if.
module nsp_out_fifo #(
    parameter int DEPTH = nsp_pkg::NSP_FIFO_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  nsp_pkg::push_t push,
    output logic          room2,
    nsp_out_if.source     words
);
    import nsp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    note_word_t      mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]   wr_ptr_plus1;
    logic            pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop          = words.valid & words.ready;
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign room2        = (cnt_reg <= CW'(DEPTH - 2));

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store words; the second lands one slot after the first
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.w0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.w1;
        end
    end

    // Present the head word
    assign words.valid     = (cnt_reg != '0);
    assign words.code      = mem_reg[rd_ptr_reg].code;
    assign words.semitones = mem_reg[rd_ptr_reg].semitones;
    assign words.octave    = mem_reg[rd_ptr_reg].octave;
    assign words.level     = mem_reg[rd_ptr_reg].level;
    assign words.duration  = mem_reg[rd_ptr_reg].duration;
    assign words.run_end   = mem_reg[rd_ptr_reg].run_end;

endmodule

// File: rtl/core/note_string_parser.sv
// Top level of the note string parser: input register, command step, config registers.
// Depends on nsp_pkg, nsp_in_if, nsp_out_if, nsp_out_fifo and the assertion macros.
//
// Characters enter on the notes channel, one per beat, and note words leave on the words
// channel. A character is taken into an input register and processed once the queue has
// room for two words, when its words (zero, one or two) are written into a queue of
// FIFO_DEPTH words; the queue registers them, and the first word is presented from there.
// The input takes one character per cycle as long as the queue has room for two words;
// the queue drains one word per cycle while the words channel is ready, so a character
// that emits two words costs twice the output bandwidth of one that emits a single word.
// start_shift (byte 0) and start_octave (byte 4) take effect at the next string start.
`include "note_string_parser_macros.svh"

module note_string_parser #(
    parameter int FIFO_DEPTH = nsp_pkg::NSP_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    nsp_in_if.sink      notes,
    nsp_out_if.source   words,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nsp_pkg::*;

    // Configuration
    shift_t  start_shift_reg;
    octave_t start_oct_reg;
    logic    cfg_wr;

    // Input register
    logic    in_v_reg;
    sym_t    sym_reg;
    logic    end_reg;
    logic    adv;
    logic    room2;

    // Parser state
    logic    pend_reg, pend_next;
    code_t   pcode_reg, pcode_next;
    shift_t  shift_reg, shift_next;
    octave_t oct_reg, oct_next;
    phase_t  phase_reg, phase_next;
    dur_t    dv_reg, dv_next;
    logic    seen_reg, seen_next;
    logic    fresh_reg;

    // Step signals
    shift_t  e_shift;
    octave_t e_oct;
    logic    e_pend;
    logic    is_digit;
    logic    is_acc;
    logic    dec_valid;
    code_t   dec_code;
    logic [3:0]  digit;
    logic [14:0] acc_sum;
    note_word_t  word_a, word_b;
    logic    a_valid, b_valid;
    push_t   push;

    function automatic shift_t shift_up(input shift_t s);
        return (s == SHIFT_MAX) ? s : shift_t'(s + 6'sd1);
    endfunction

    function automatic shift_t shift_down(input shift_t s);
        return (s == SHIFT_MIN) ? s : shift_t'(s - 6'sd1);
    endfunction

    function automatic note_word_t make_word(input code_t c, input shift_t s,
                                             input octave_t o, input dur_t dv,
                                             input logic seen);
        note_word_t w;
        w.code      = c;
        w.semitones = s;
        w.octave    = o;
        w.run_end   = 1'b0;
        if (c == CODE_VELOCITY || c == CODE_MODULATION)
        begin
            if (seen)
                w.level = (dv > dur_t'(MAX_LEVEL)) ? MAX_LEVEL : dv[6:0];
            else
                w.level = (c == CODE_MODULATION) ? 7'd0 : DEF_LEVEL;
            w.duration = DEF_LENGTH;
        end
        else
        begin
            w.level    = DEF_LEVEL;
            w.duration = seen ? dv : DEF_LENGTH;
        end
        return w;
    endfunction

    // Config port: always ready, write on the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_shift_reg <= RST_START_SHIFT;
            start_oct_reg   <= RST_START_OCTAVE;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_START_SHIFT:  start_shift_reg <= shift_t'(pwdata[5:0]);
                REG_START_OCTAVE: start_oct_reg   <= pwdata[2:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_START_SHIFT:  prdata = {26'd0, start_shift_reg};
            REG_START_OCTAVE: prdata = {29'd0, start_oct_reg};
            default:          prdata = '0;
        endcase
    end

    // Input register: hold a character until the queue can take two words
    assign adv          = in_v_reg & room2;
    assign notes.ready  = ~in_v_reg | room2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (notes.ready)
        begin
            in_v_reg <= notes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (notes.valid & notes.ready)
        begin
            sym_reg <= notes.symbol;
            end_reg <= notes.string_end;
        end
    end

    // Decode the character
    always_comb
    begin
        dec_valid = 1'b1;
        dec_code  = CODE_NOTE_A;
        if (sym_reg >= CHAR_A && sym_reg <= CHAR_G)
        begin
            dec_code = code_t'(sym_reg - CHAR_A);
        end
        else
        begin
            case (sym_reg)
                CHAR_R:      dec_code = CODE_REST;
                CHAR_PLUS:   dec_code = CODE_PLUS;
                CHAR_MINUS:  dec_code = CODE_MINUS;
                CHAR_HASH:   dec_code = CODE_SHARP;
                CHAR_EQUAL:  dec_code = CODE_NATURAL;
                CHAR_LBRACK: dec_code = CODE_OCT_UP;
                CHAR_LESS:   dec_code = CODE_OCT_UP;
                CHAR_RBRACK: dec_code = CODE_OCT_DOWN;
                CHAR_MORE:   dec_code = CODE_OCT_DOWN;
                CHAR_V:      dec_code = CODE_VELOCITY;
                CHAR_M:      dec_code = CODE_MODULATION;
                default:     dec_valid = 1'b0;
            endcase
        end
    end

    assign is_digit = (sym_reg >= CHAR_0) && (sym_reg <= CHAR_9);
    assign digit    = 4'(sym_reg - CHAR_0);
    assign acc_sum  = {4'd0, dv_reg} * 15'd10 + {11'd0, digit};

    // Start-of-string view of the state
    assign e_shift = fresh_reg ? start_shift_reg : shift_reg;
    assign e_oct   = fresh_reg ? start_oct_reg : oct_reg;
    assign e_pend  = pend_reg & ~fresh_reg;
    assign is_acc  = (sym_reg == CHAR_HASH || sym_reg == CHAR_EQUAL) && e_pend &&
                     (phase_reg != 2'd0) && !seen_reg;

    // Command step: accumulate digits, apply accidentals, or emit and open any new command
    always_comb
    begin
        pend_next  = e_pend;
        pcode_next = pcode_reg;
        shift_next = e_shift;
        oct_next   = e_oct;
        phase_next = phase_reg;
        dv_next    = dv_reg;
        seen_next  = seen_reg;
        a_valid    = 1'b0;
        word_a     = make_word(pcode_reg, e_shift, e_oct, dv_reg, seen_reg);

        if (is_digit)
        begin
            if (e_pend)
            begin
                seen_next  = 1'b1;
                phase_next = 2'd0;
                dv_next    = (acc_sum > 15'(MAX_LENGTH)) ? MAX_LENGTH : acc_sum[10:0];
            end
        end
        else if (is_acc)
        begin
            if (sym_reg == CHAR_HASH)
                shift_next = shift_up((phase_reg == 2'd1) ? 6'sd0 : e_shift);
            else
                shift_next = shift_down((phase_reg == 2'd1) ? 6'sd0 : e_shift);
            phase_next = (phase_reg == 2'd3) ? 2'd0 : phase_reg + 2'd1;
        end
        else
        begin
            a_valid    = e_pend;
            pend_next  = dec_valid;
            pcode_next = dec_valid ? dec_code : CODE_NOTE_A;
            dv_next    = '0;
            seen_next  = 1'b0;
            phase_next = (dec_valid && dec_code <= CODE_NOTE_G) ? 2'd1 : 2'd0;
            if (dec_valid)
            begin
                if (dec_code <= CODE_NOTE_G)
                begin
                    shift_next = 6'sd0;
                end
                else
                begin
                    case (dec_code)
                        CODE_PLUS:     shift_next = shift_up(e_shift);
                        CODE_SHARP:    shift_next = shift_up(e_shift);
                        CODE_MINUS:    shift_next = shift_down(e_shift);
                        CODE_NATURAL:  shift_next = shift_down(e_shift);
                        CODE_OCT_UP:   oct_next = (e_oct == OCT_MAX) ? e_oct : e_oct + 3'd1;
                        CODE_OCT_DOWN: oct_next = (e_oct == 3'd0) ? e_oct : e_oct - 3'd1;
                        default:       ;
                    endcase
                end
            end
        end

        // Flush the pending command at the end of the string
        word_b  = make_word(pcode_next, shift_next, oct_next, dv_next, seen_next);
        b_valid = end_reg & pend_next;
        if (end_reg)
        begin
            pend_next  = 1'b0;
            pcode_next = CODE_NOTE_A;
            dv_next    = '0;
            seen_next  = 1'b0;
            phase_next = 2'd0;
        end
    end

    // Pack the words for the queue; run_end goes on the last word of the string
    always_comb
    begin
        push.count = adv ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
        push.w0    = a_valid ? word_a : word_b;
        push.w0.run_end = end_reg & ~(a_valid & b_valid);
        push.w1    = word_b;
        push.w1.run_end = 1'b1;
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            pcode_reg <= CODE_NOTE_A;
            shift_reg <= RST_START_SHIFT;
            oct_reg   <= RST_START_OCTAVE;
            phase_reg <= 2'd0;
            dv_reg    <= '0;
            seen_reg  <= 1'b0;
            fresh_reg <= 1'b1;
        end
        else if (adv)
        begin
            pend_reg  <= pend_next;
            pcode_reg <= pcode_next;
            shift_reg <= shift_next;
            oct_reg   <= oct_next;
            phase_reg <= phase_next;
            dv_reg    <= dv_next;
            seen_reg  <= seen_next;
            fresh_reg <= end_reg;
        end
    end

    nsp_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room2 (room2),
        .words (words)
    );

    // Checks
    `NSP_ASSERT_NOW(a_fresh_idle, fresh_reg, !pend_reg)
    `NSP_ASSERT_NOW(a_digits_pending, seen_reg, pend_reg && phase_reg == 2'd0)
    `NSP_ASSERT_NEXT(a_stall_holds, in_v_reg && !room2, in_v_reg && $stable(sym_reg))
    `NSP_ASSERT_NEXT(a_end_flushes, adv && end_reg, fresh_reg && !pend_reg)

endmodule

// File: verif/tb_note_string_parser.sv
// Self-checking testbench for note_string_parser: drives note strings as character beats,
// predicts every note word and compares it field by field with the words channel.
// Depends on nsp_pkg, nsp_in_if, nsp_out_if and the note_string_parser RTL.
module tb_note_string_parser;
    import nsp_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int PHASES        = 6;
    localparam int MAX_REPORTS   = 40;

    localparam sym_t CHAR_SPACE = 8'h20;
    localparam sym_t CHAR_NUL   = 8'h00;
    localparam sym_t CHAR_TOP   = 8'hFF;

    // Every character that opens a command except M, which is drawn separately
    localparam sym_t CMD_CHARS [17] = '{
        CHAR_A, sym_t'(CHAR_A + 8'd1), sym_t'(CHAR_A + 8'd2), sym_t'(CHAR_A + 8'd3),
        sym_t'(CHAR_A + 8'd4), sym_t'(CHAR_A + 8'd5), CHAR_G, CHAR_R,
        CHAR_PLUS, CHAR_MINUS, CHAR_HASH, CHAR_EQUAL,
        CHAR_LBRACK, CHAR_LESS, CHAR_RBRACK, CHAR_MORE, CHAR_V
    };

    // One character beat, optionally with its word typed in
    typedef struct packed {
        sym_t       sym;
        logic       last;
        logic       pinned;
        logic       has_word;
        note_word_t w;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nsp_in_if  notes ();
    nsp_out_if words ();

    note_string_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .notes   (notes),
        .words   (words),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Parser state as the predictor sees it
    logic    pend_valid    = 1'b0;
    code_t   pend_code     = CODE_NOTE_A;
    int      shift_now     = int'(RST_START_SHIFT);
    int      oct_now       = int'(RST_START_OCTAVE);
    phase_t  acc_phase     = '0;
    int      num_val       = 0;
    logic    num_seen      = 1'b0;
    logic    fresh         = 1'b1;
    shift_t  start_shift_q = RST_START_SHIFT;
    octave_t start_oct_q   = RST_START_OCTAVE;

    note_word_t char_words [$];
    note_word_t pending_words [$];

    int errors     = 0;
    int reports    = 0;
    int cycles     = 0;
    int items_sent = 0;
    bit steady     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic stim_row_t plain_row(sym_t s, logic last);
        stim_row_t r;
        r      = '0;
        r.sym  = s;
        r.last = last;
        return r;
    endfunction

    function automatic stim_row_t pin_row(sym_t s, logic last, logic has_word, note_word_t w);
        stim_row_t r;
        r          = plain_row(s, last);
        r.pinned   = 1'b1;
        r.has_word = has_word;
        r.w        = w;
        return r;
    endfunction

    // Saturating shift step
    function automatic void step_shift(int delta);
        shift_now = shift_now + delta;
        if (shift_now > int'(SHIFT_MAX))
            shift_now = int'(SHIFT_MAX);
        if (shift_now < int'(SHIFT_MIN))
            shift_now = int'(SHIFT_MIN);
    endfunction

    // Emit the held command as a word and clear its number
    function automatic void close_pending();
        note_word_t w;
        if (!pend_valid)
            return;
        w.code      = pend_code;
        w.semitones = shift_t'(shift_now);
        w.octave    = octave_t'(oct_now);
        w.run_end   = 1'b0;
        if (pend_code == CODE_VELOCITY || pend_code == CODE_MODULATION)
        begin
            w.duration = DEF_LENGTH;
            if (num_seen)
                w.level = (num_val > int'(MAX_LEVEL)) ? MAX_LEVEL : level_t'(num_val);
            else
                w.level = (pend_code == CODE_MODULATION) ? level_t'(0) : DEF_LEVEL;
        end
        else
        begin
            w.level    = DEF_LEVEL;
            w.duration = num_seen ? dur_t'(num_val) : DEF_LENGTH;
        end
        char_words.push_back(w);
        pend_valid = 1'b0;
        pend_code  = CODE_NOTE_A;
        num_val    = 0;
        num_seen   = 1'b0;
        acc_phase  = '0;
    endfunction

    // Work out the words that one accepted character releases
    function automatic void predict_char(sym_t s, logic last);
        code_t      cmd;
        logic       is_cmd;
        note_word_t tail;
        char_words.delete();
        if (fresh)
        begin
            shift_now  = int'(start_shift_q);
            oct_now    = int'(start_oct_q);
            pend_valid = 1'b0;
            num_val    = 0;
            num_seen   = 1'b0;
            acc_phase  = '0;
        end
        if (s >= CHAR_0 && s <= CHAR_9)
        begin
            // digits only count behind a command
            if (pend_valid)
            begin
                num_seen  = 1'b1;
                acc_phase = '0;
                num_val   = num_val * 10 + int'(s - CHAR_0);
                if (num_val > int'(MAX_LENGTH))
                    num_val = int'(MAX_LENGTH);
            end
        end
        else if ((s == CHAR_HASH || s == CHAR_EQUAL) && pend_valid && acc_phase != 2'd0
                 && !num_seen)
        begin
            // accidental attached to the held note
            if (acc_phase == 2'd1)
                shift_now = 0;
            step_shift((s == CHAR_HASH) ? 1 : -1);
            acc_phase = (acc_phase == 2'd3) ? 2'd0 : acc_phase + 2'd1;
        end
        else
        begin
            is_cmd = 1'b1;
            cmd    = CODE_NOTE_A;
            if (s >= CHAR_A && s <= CHAR_G)
                cmd = code_t'(s - CHAR_A);
            else
            begin
                case (s)
                    CHAR_R:                cmd = CODE_REST;
                    CHAR_PLUS:             cmd = CODE_PLUS;
                    CHAR_MINUS:            cmd = CODE_MINUS;
                    CHAR_HASH:             cmd = CODE_SHARP;
                    CHAR_EQUAL:            cmd = CODE_NATURAL;
                    CHAR_LBRACK, CHAR_LESS: cmd = CODE_OCT_UP;
                    CHAR_RBRACK, CHAR_MORE: cmd = CODE_OCT_DOWN;
                    CHAR_V:                cmd = CODE_VELOCITY;
                    CHAR_M:                cmd = CODE_MODULATION;
                    default:               is_cmd = 1'b0;
                endcase
            end
            close_pending();
            if (is_cmd)
            begin
                case (cmd)
                    CODE_PLUS, CODE_SHARP:     step_shift(1);
                    CODE_MINUS, CODE_NATURAL:  step_shift(-1);
                    CODE_OCT_UP:
                        if (oct_now < int'(OCT_MAX))
                            oct_now++;
                    CODE_OCT_DOWN:
                        if (oct_now > 0)
                            oct_now--;
                    default:
                        if (cmd <= CODE_NOTE_G)
                            shift_now = 0;
                endcase
                pend_valid = 1'b1;
                pend_code  = cmd;
                num_val    = 0;
                num_seen   = 1'b0;
                acc_phase  = (cmd <= CODE_NOTE_G) ? 2'd1 : 2'd0;
            end
        end
        if (last)
        begin
            close_pending();
            if (char_words.size() > 0)
            begin
                tail         = char_words.pop_back();
                tail.run_end = 1'b1;
                char_words.push_back(tail);
            end
            fresh = 1'b1;
        end
        else
            fresh = 1'b0;
    endfunction

    // Drive one character beat, wait for it to be taken, then log its words
    task automatic send_char(stim_row_t r);
        int gap;
        notes.valid      <= 1'b1;
        notes.symbol     <= r.sym;
        notes.string_end <= r.last;
        do
            @(posedge clk);
        while (!notes.ready);
        predict_char(r.sym, r.last);
        if (r.pinned)
        begin
            if (r.has_word)
                pending_words.push_back(r.w);
        end
        else
        begin
            foreach (char_words[i])
                pending_words.push_back(char_words[i]);
        end
        items_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            notes.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the input until every word is out, then let the pipeline settle
    task automatic wait_drained();
        notes.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_start(shift_t sh, octave_t oc);
        write_reg(REG_START_SHIFT, {{26{sh[5]}}, sh});
        write_reg(REG_START_OCTAVE, {29'd0, oc});
        start_shift_q = sh;
        start_oct_q   = oc;
    endtask

    // Build one note string: mostly commands with accidentals and numbers, some noise
    task automatic send_random_string();
        sym_t chars [$];
        int   tokens;
        int   r;
        int   k;
        sym_t c;
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 6))
                chars.push_back(sym_t'($urandom_range(0, 255)));
        end
        else
        begin
            tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            repeat (tokens)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    chars.push_back($urandom_range(0, 1) ? CHAR_SPACE
                                                         : sym_t'($urandom_range(0, 255)));
                else if (r < 11)
                    chars.push_back(sym_t'(CHAR_0 + $urandom_range(0, 9)));
                else
                begin
                    c = ($urandom_range(0, 16) == 0) ? CHAR_M : CMD_CHARS[$urandom_range(0, 16)];
                    chars.push_back(c);
                    if (c >= CHAR_A && c <= CHAR_G && $urandom_range(0, 1) == 1)
                    begin
                        repeat ($urandom_range(1, 4))
                            chars.push_back($urandom_range(0, 1) ? CHAR_HASH : CHAR_EQUAL);
                    end
                    r = $urandom_range(0, 99);
                    k = (r < 40) ? 0 : (r < 88) ? $urandom_range(1, 3) : $urandom_range(4, 5);
                    repeat (k)
                        chars.push_back(sym_t'(CHAR_0 + $urandom_range(0, 9)));
                    if (k > 0 && $urandom_range(0, 9) == 0)
                        chars.push_back($urandom_range(0, 1) ? CHAR_HASH : CHAR_EQUAL);
                end
            end
            if ($urandom_range(0, 6) == 0)
                chars.push_back(CHAR_SPACE);
        end
        steady = ($urandom_range(0, 4) == 0);
        foreach (chars[i])
            send_char(plain_row(chars[i], i == chars.size() - 1));
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            if (reports < MAX_REPORTS)
            begin
                reports++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endfunction

    // Compare every word beat with the oldest expected word
    always @(posedge clk)
    begin
        note_word_t want;
        if (rst_n && words.valid && words.ready)
        begin
            if (pending_words.size() == 0)
            begin
                errors++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("%0t: unexpected word, expected none, actual code %0d",
                             $time, words.code);
                end
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("code", int'(want.code), int'(words.code));
                check_field("semitones", int'(want.semitones), int'(words.semitones));
                check_field("octave", int'(want.octave), int'(words.octave));
                check_field("level", int'(want.level), int'(words.level));
                check_field("duration", int'(want.duration), int'(words.duration));
                check_field("run_end", int'(want.run_end), int'(words.run_end));
            end
        end
    end

    // Stall the words channel: short and long stalls, plus stretches with none
    initial
    begin
        int stall;
        words.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            words.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat (60) @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 8)) @(posedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    words.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        stim_row_t dir_rows [$];
        int        base;
        rst_n            <= 1'b0;
        notes.valid      <= 1'b0;
        notes.symbol     <= CHAR_NUL;
        notes.string_end <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single note and single shift step, each closing its string
        dir_rows.push_back(pin_row(CHAR_A, 1'b1, 1'b1,
                           '{CODE_NOTE_A, 6'sd0, 3'd4, DEF_LEVEL, DEF_LENGTH, 1'b1}));
        dir_rows.push_back(pin_row(CHAR_PLUS, 1'b1, 1'b1,
                           '{CODE_PLUS, 6'sd2, 3'd4, DEF_LEVEL, DEF_LENGTH, 1'b1}));
        // stray digit with nothing held
        dir_rows.push_back(pin_row(sym_t'(CHAR_0 + 8'd5), 1'b0, 1'b0, '0));
        // note with three accidentals, then a fourth that stands alone
        dir_rows.push_back(plain_row(CHAR_G, 1'b0));
        dir_rows.push_back(plain_row(CHAR_EQUAL, 1'b0));
        dir_rows.push_back(plain_row(CHAR_HASH, 1'b0));
        dir_rows.push_back(plain_row(CHAR_HASH, 1'b0));
        dir_rows.push_back(plain_row(CHAR_HASH, 1'b0));
        // saturating length, then an accidental after digits
        dir_rows.push_back(plain_row(CHAR_A + 8'd2, 1'b0));
        repeat (4)
            dir_rows.push_back(plain_row(CHAR_9, 1'b0));
        dir_rows.push_back(plain_row(CHAR_HASH, 1'b0));
        // velocity above its ceiling, modulation with no number
        dir_rows.push_back(plain_row(CHAR_V, 1'b0));
        dir_rows.push_back(plain_row(sym_t'(CHAR_0 + 8'd2), 1'b0));
        dir_rows.push_back(plain_row(CHAR_0, 1'b0));
        dir_rows.push_back(plain_row(CHAR_0, 1'b0));
        dir_rows.push_back(plain_row(CHAR_M, 1'b0));
        dir_rows.push_back(plain_row(CHAR_TOP, 1'b0));
        dir_rows.push_back(plain_row(CHAR_LESS, 1'b0));
        dir_rows.push_back(plain_row(CHAR_MINUS, 1'b0));
        dir_rows.push_back(plain_row(CHAR_NUL, 1'b0));
        // two words in one beat, then a string whose last beat emits nothing
        dir_rows.push_back(plain_row(CHAR_R, 1'b0));
        dir_rows.push_back(plain_row(CHAR_MORE, 1'b1));
        dir_rows.push_back(pin_row(CHAR_SPACE, 1'b1, 1'b0, '0));

        foreach (dir_rows[i])
            send_char(dir_rows[i]);
        base = items_sent;

        // random strings under several start settings, extremes first
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:       set_start(SHIFT_MAX, OCT_MAX);
                1:       set_start(SHIFT_MIN, 3'd0);
                2:       set_start(6'sd0, 3'd2);
                3, 4:    set_start(shift_t'($urandom_range(0, 63)), octave_t'($urandom_range(0, 7)));
                default: set_start(RST_START_SHIFT, RST_START_OCTAVE);
            endcase
            while (items_sent < base + (phase + 1) * RANDOM_ITEMS / PHASES)
                send_random_string();
        end

        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
